// File: rtl/core/kms_pkg.sv
package kms_pkg;

    // Matrix geometry and special key positions
    localparam int unsigned NUM_ROWS_DEF   = 11;
    localparam int unsigned ROW_IDX_W      = 4;
    localparam int unsigned COL_W          = 3;
    localparam int unsigned COLS           = 8;
    localparam int unsigned KEYS_W         = 7;
    localparam int unsigned CNT_W          = 4;
    localparam logic [3:0]  MOD_ROW        = 4'd6;
    localparam logic [7:0]  MOD_MASK       = 8'h17;
    localparam logic [2:0]  CAPS_COLUMN    = 3'd3;

    // Configuration registers
    localparam int unsigned CFG_W          = 8;
    localparam logic [7:0]  FIRST_DELAY_RST     = 8'd30;
    localparam logic [7:0]  REPEAT_INTERVAL_RST = 8'd5;

    typedef enum logic [0:0] {
        CFG_FIRST_DELAY     = 1'b0,
        CFG_REPEAT_INTERVAL = 1'b1
    } cfg_index_t;

    // Result of comparing one row with the stored map
    typedef struct packed {
        logic             mod_change;
        logic             any_press;
        logic [COL_W-1:0] press_col;
        logic [CNT_W-1:0] presses;
        logic [CNT_W-1:0] releases;
    } row_eval_t;

endpackage

// File: rtl/core/kms_row_eval.sv
module kms_row_eval
    import kms_pkg::*;
(
    input  logic [7:0] now,
    input  logic [7:0] prev,
    input  logic       is_mod_row,
    output row_eval_t  eval
);

    logic [7:0] diff;
    logic [7:0] mods;
    logic [7:0] press;
    logic [7:0] rel;

    // Split the change into presses and releases of ordinary keys
    always_comb
    begin
        diff  = now ^ prev;
        mods  = is_mod_row ? MOD_MASK : 8'h00;
        press = diff & ~mods & ~prev;
        rel   = diff & ~mods & prev;
    end

    // Count changes and take the highest newly pressed column
    always_comb
    begin
        eval.mod_change = |(diff & mods);
        eval.any_press  = |press;
        eval.press_col  = '0;
        eval.presses    = '0;
        eval.releases   = '0;
        for (int n = 0; n < COLS; n++)
        begin
            if (press[n])
            begin
                eval.press_col = COL_W'(n);
            end
            eval.presses  = eval.presses + CNT_W'(press[n]);
            eval.releases = eval.releases + CNT_W'(rel[n]);
        end
    end

endmodule

// File: rtl/core/key_matrix_scanner_with_repeat.sv
// Key matrix scanner with typematic repeat.
// Input channel s_*: one matrix row per item (row index and raw active-low
// port byte). The last row (NUM_ROWS-1) closes a scan; rows at or beyond
// NUM_ROWS are dropped without effect.
// Output channel m_*: at most one key event per scan, produced when the
// closing row is processed: a new press, or expiry of the 8-bit repeat
// timer while a key stays held. The caps-lock key toggles the caps state
// and produces no event.
// Config port cfg_*: index 0 first_delay, index 1 repeat_interval; write
// only while no item is in flight.
// Path: an item is registered in the input register, evaluated from it
// combinationally, and its event is registered in the output register for m_*.
// Throughput: one item per cycle while the output register is empty or its
// event is being taken; the map, counter and timer update when an item is
// evaluated, so each item sees the state left by the one before it.
// Reset clears the key map, counters, timer, caps state and both channels;
// the registers return to 30 and 5. When the receiver stalls, one event
// waits in the output register, one item waits in the input register and
// s_tready drops until the event is taken.
module key_matrix_scanner_with_repeat
    import kms_pkg::*;
#(
    parameter int unsigned NUM_ROWS = NUM_ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] row_index, [11:4] row_port_bits, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] key_row, [6:4] key_column, [7] shift_held,
                                   // [8] ctrl_held, [9] caps_lock_on, [10] is_repeat,
                                   // [15:11] zero
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int unsigned ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam logic [ROW_IDX_W-1:0] END_ROW = ROW_IDX_W'(NUM_ROWS - 1);
    localparam logic [ROW_IDX_W:0]   ROW_LIMIT = (ROW_IDX_W + 1)'(NUM_ROWS);

    // Configuration
    logic [CFG_W-1:0] first_delay_reg;
    logic [CFG_W-1:0] repeat_interval_reg;

    // Input register
    logic                 in_valid_reg;
    logic [ROW_IDX_W-1:0] in_row_reg;
    logic [7:0]           in_bits_reg;

    // Scanner state
    logic [7:0]           prior_map_reg [NUM_ROWS];
    logic [KEYS_W-1:0]    keys_down_reg;
    logic [7:0]           repeat_timer_reg;
    logic                 new_press_reg;
    logic [ROW_IDX_W-1:0] last_row_reg;
    logic [COL_W-1:0]     last_column_reg;
    logic                 caps_flag_reg;

    // Output register
    logic                 out_valid_reg;
    logic [15:0]          out_data_reg;

    // Next values
    logic [KEYS_W-1:0]    keys_down_next;
    logic [7:0]           repeat_timer_next;
    logic                 new_press_next;
    logic [ROW_IDX_W-1:0] last_row_next;
    logic [COL_W-1:0]     last_column_next;
    logic                 caps_flag_next;
    logic                 emit_next;
    logic [15:0]          out_data_next;

    logic                 advance;
    logic                 row_ok;
    logic [ROW_W-1:0]     row_idx;
    logic [7:0]           now_bits;
    logic [7:0]           prev_bits;
    logic [7:0]           mod_row_stored;
    logic [7:0]           mod_row_bits;
    logic                 is_mod_row;
    row_eval_t            eval;
    logic [7:0]           timer_a;
    logic [7:0]           timer_dec;
    logic                 press_a;

    // Handshake: the evaluation stage moves when it holds an item and the output slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg     <= FIRST_DELAY_RST;
            repeat_interval_reg <= REPEAT_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FIRST_DELAY:     first_delay_reg     <= cfg_data;
                CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Capture input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_row_reg  <= s_tdata[3:0];
            in_bits_reg <= s_tdata[11:4];
        end
    end

    // Look up the stored row and the modifier row
    assign row_ok     = {1'b0, in_row_reg} < ROW_LIMIT;
    assign row_idx    = in_row_reg[ROW_W-1:0];
    assign now_bits   = ~in_bits_reg;
    assign prev_bits  = prior_map_reg[row_idx];
    assign is_mod_row = (in_row_reg == MOD_ROW);

    generate
        if (NUM_ROWS > 6)
        begin : g_mod_row
            localparam logic [ROW_W-1:0] MOD_IDX = ROW_W'(MOD_ROW);
            assign mod_row_stored = prior_map_reg[MOD_IDX];
        end
        else
        begin : g_no_mod_row
            assign mod_row_stored = 8'h00;
        end
    endgenerate

    assign mod_row_bits = is_mod_row ? now_bits : mod_row_stored;

    kms_row_eval u_row_eval (
        .now        (now_bits),
        .prev       (prev_bits),
        .is_mod_row (is_mod_row),
        .eval       (eval)
    );

    // Update counters and decide on an event
    always_comb
    begin
        keys_down_next   = keys_down_reg + KEYS_W'(eval.presses) - KEYS_W'(eval.releases);
        timer_a          = eval.mod_change ? first_delay_reg : repeat_timer_reg;
        timer_dec        = timer_a - 8'd1;
        press_a          = new_press_reg || eval.any_press;
        last_row_next    = eval.any_press ? in_row_reg : last_row_reg;
        last_column_next = eval.any_press ? eval.press_col : last_column_reg;
        caps_flag_next   = caps_flag_reg;
        emit_next        = 1'b0;
        repeat_timer_next = timer_a;
        new_press_next   = press_a;
        out_data_next    = '0;

        if (in_row_reg == END_ROW)
        begin
            new_press_next = 1'b0;
            if (keys_down_next != '0)
            begin
                if (press_a)
                begin
                    emit_next         = 1'b1;
                    repeat_timer_next = first_delay_reg;
                end
                else
                begin
                    repeat_timer_next = timer_dec;
                    if (timer_dec == 8'd0)
                    begin
                        emit_next         = 1'b1;
                        repeat_timer_next = repeat_interval_reg;
                    end
                end
            end
        end

        // Caps lock toggles instead of producing an event
        if (emit_next && last_row_next == MOD_ROW && last_column_next == CAPS_COLUMN)
        begin
            emit_next      = 1'b0;
            caps_flag_next = !caps_flag_reg;
        end

        out_data_next[3:0]  = last_row_next;
        out_data_next[6:4]  = last_column_next;
        out_data_next[7]    = mod_row_bits[0];
        out_data_next[8]    = mod_row_bits[1];
        out_data_next[9]    = caps_flag_reg;
        out_data_next[10]   = !press_a;
    end

    // Commit scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                prior_map_reg[i] <= 8'h00;
            end
            keys_down_reg    <= '0;
            repeat_timer_reg <= '0;
            new_press_reg    <= 1'b0;
            last_row_reg     <= '0;
            last_column_reg  <= '0;
            caps_flag_reg    <= 1'b0;
        end
        else if (advance && row_ok)
        begin
            prior_map_reg[row_idx] <= now_bits;
            keys_down_reg    <= keys_down_next;
            repeat_timer_reg <= repeat_timer_next;
            new_press_reg    <= new_press_next;
            last_row_reg     <= last_row_next;
            last_column_reg  <= last_column_next;
            caps_flag_reg    <= caps_flag_next;
        end
    end

    // Hold the event until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= row_ok && emit_next;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && row_ok && emit_next)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
